>>> hw/rtl/ght_pkg.sv
// shared constants and codes for the generational handle table
package ght_pkg;

   localparam int SLOTS      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int POS_W      = $clog2(SLOTS + 1);

   localparam int KIND_W     = 3;
   localparam int HIDX_W     = 5;
   localparam int REV_W      = 32;
   localparam int VAL_W      = 32;

   localparam int REQ_DATA_W = ((HIDX_W + REV_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((HIDX_W + REV_W + VAL_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD        = 3'd0,
      KIND_GET        = 3'd1,
      KIND_REMOVE     = 3'd2,
      KIND_ITER_START = 3'd3,
      KIND_ITER_NEXT  = 3'd4
   } kind_type;

endpackage

>>> hw/rtl/generational_handle_table_top.sv
// generational handle table: slot allocation, checked lookup and removal, used-slot iteration
//
//  channel  dir  tdata (low bit up)                                  tuser
//  req_     in   slot_index[4:0], handle_revision[36:5],             kind[2:0]
//                entry_value[68:37], zero pad to 72
//  rsp_     out  out_index[4:0], out_revision[36:5],                 ok[0]
//                out_value[68:37], zero pad to 72
//
// in-range get and remove go through S_READ and S_CHECK; iterator start, unknown kinds go to S_DONE
// add and iterator next: S_SCAN steps through the used flags with the single slot compare and
//   increment step, then S_READ and S_CHECK when a slot is found, or S_DONE when the scan runs out
// reset clears the used flags, the valid bits of both tables and the scan position
// a new beat is taken while a finished result still waits on rsp_tready
module generational_handle_table_top
   import ght_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slot_index, handle_revision, entry_value
   input  logic [KIND_W-1:0]     req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_index, out_revision, out_value
   output logic                  rsp_tuser    // ok
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [KIND_W-1:0]      kind_ff;
   logic [REV_W-1:0]       rev_ff;
   logic [DATA_WIDTH-1:0]  val_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic [POS_W-1:0]       ptr_ff;
   logic [POS_W-1:0]       scan_pos_ff;
   logic [SLOTS-1:0]       used_ff;
   logic [SLOTS-1:0]       rev_vld_ff;
   logic [SLOTS-1:0]       data_vld_ff;

   logic                   res_ok_ff;
   logic [HIDX_W-1:0]      res_idx_ff;
   logic [REV_W-1:0]       res_rev_ff;
   logic [VAL_W-1:0]       res_val_ff;

   logic                   rsp_tvalid_ff;
   logic                   rsp_ok_ff;
   logic [HIDX_W-1:0]      rsp_idx_ff;
   logic [REV_W-1:0]       rsp_rev_ff;
   logic [VAL_W-1:0]       rsp_val_ff;

   logic [REV_W-1:0]       rev_mem [SLOTS];
   logic [DATA_WIDTH-1:0]  data_mem [SLOTS];
   logic [REV_W-1:0]       rev_rd_ff;
   logic [DATA_WIDTH-1:0]  data_rd_ff;

   logic                   rev_we;
   logic [REV_W-1:0]       rev_wdata;
   logic                   data_we;
   logic [IDX_W-1:0]       data_waddr;

   logic                   accept;
   logic                   rsp_load;
   logic [HIDX_W-1:0]      in_idx;
   logic [REV_W-1:0]       in_rev;
   logic [VAL_W-1:0]       in_val;
   logic                   in_range;
   logic                   ptr_end;
   logic [IDX_W-1:0]       ptr_idx;
   logic                   ptr_hit;
   logic [POS_W-1:0]       ptr_inc;
   logic [REV_W-1:0]       rev_q;
   logic [DATA_WIDTH-1:0]  data_q;
   logic                   rev_match;

   assign in_idx   = req_tdata[HIDX_W-1:0];
   assign in_rev   = req_tdata[HIDX_W+REV_W-1:HIDX_W];
   assign in_val   = req_tdata[HIDX_W+REV_W+VAL_W-1:HIDX_W+REV_W];
   assign in_range = 32'(in_idx) < 32'(SLOTS);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // shared scan step: one slot compare and increment per cycle
   assign ptr_end = (ptr_ff == POS_W'(SLOTS));
   assign ptr_idx = ptr_ff[IDX_W-1:0];
   assign ptr_inc = ptr_ff + POS_W'(1);
   assign ptr_hit = (kind_ff == KIND_ADD) ? !used_ff[ptr_idx] : used_ff[ptr_idx];

   assign rev_q     = rev_vld_ff[addr_ff] ? rev_rd_ff : '0;
   assign data_q    = data_vld_ff[addr_ff] ? data_rd_ff : '0;
   assign rev_match = (rev_q == rev_ff);

   assign rev_we     = (state_ff == S_CHECK) && (kind_ff == KIND_REMOVE) && rev_match;
   assign rev_wdata  = rev_q + REV_W'(1);
   assign data_we    = (state_ff == S_SCAN) && (kind_ff == KIND_ADD) && !ptr_end && ptr_hit;
   assign data_waddr = ptr_idx;

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[addr_ff] <= rev_wdata;
      end
      if (data_we) begin
         data_mem[data_waddr] <= val_ff;
      end
      rev_rd_ff  <= rev_mem[addr_ff];
      data_rd_ff <= data_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         kind_ff       <= '0;
         rev_ff        <= '0;
         val_ff        <= '0;
         addr_ff       <= '0;
         ptr_ff        <= '0;
         scan_pos_ff   <= '0;
         used_ff       <= '0;
         rev_vld_ff    <= '0;
         data_vld_ff   <= '0;
         res_ok_ff     <= 1'b0;
         res_idx_ff    <= '0;
         res_rev_ff    <= '0;
         res_val_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_ok_ff     <= 1'b0;
         rsp_idx_ff    <= '0;
         rsp_rev_ff    <= '0;
         rsp_val_ff    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff    <= req_tuser;
                  rev_ff     <= in_rev;
                  val_ff     <= DATA_WIDTH'(in_val);
                  addr_ff    <= IDX_W'(in_idx);
                  res_ok_ff  <= (req_tuser == KIND_ITER_START);
                  res_idx_ff <= '0;
                  res_rev_ff <= '0;
                  res_val_ff <= '0;
                  case (req_tuser)
                     KIND_ADD: begin
                        ptr_ff   <= '0;
                        state_ff <= S_SCAN;
                     end
                     KIND_GET, KIND_REMOVE: begin
                        state_ff <= in_range ? S_READ : S_DONE;
                     end
                     KIND_ITER_START: begin
                        scan_pos_ff <= '0;
                        state_ff    <= S_DONE;
                     end
                     KIND_ITER_NEXT: begin
                        ptr_ff   <= scan_pos_ff;
                        state_ff <= S_SCAN;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (ptr_end) begin
                  state_ff <= S_DONE;
               end else begin
                  ptr_ff <= ptr_inc;
                  if (kind_ff == KIND_ITER_NEXT) begin
                     scan_pos_ff <= ptr_inc;
                  end
                  if (ptr_hit) begin
                     addr_ff  <= ptr_idx;
                     state_ff <= S_READ;
                     if (kind_ff == KIND_ADD) begin
                        used_ff[ptr_idx]     <= 1'b1;
                        data_vld_ff[ptr_idx] <= 1'b1;
                     end
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= S_DONE;
               case (kind_ff)
                  KIND_ADD: begin
                     res_ok_ff  <= 1'b1;
                     res_idx_ff <= HIDX_W'(addr_ff);
                     res_rev_ff <= rev_q;
                  end
                  KIND_GET: begin
                     res_ok_ff  <= rev_match;
                     res_val_ff <= rev_match ? VAL_W'(data_q) : '0;
                  end
                  KIND_REMOVE: begin
                     res_ok_ff <= rev_match;
                     if (rev_match) begin
                        used_ff[addr_ff]    <= 1'b0;
                        rev_vld_ff[addr_ff] <= 1'b1;
                     end
                  end
                  KIND_ITER_NEXT: begin
                     res_ok_ff  <= 1'b1;
                     res_idx_ff <= HIDX_W'(addr_ff);
                     res_val_ff <= VAL_W'(data_q);
                  end
                  default: begin
                     res_ok_ff <= 1'b0;
                  end
               endcase
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ok_ff     <= res_ok_ff;
                  rsp_idx_ff    <= res_idx_ff;
                  rsp_rev_ff    <= res_rev_ff;
                  rsp_val_ff    <= res_val_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_val_ff, rsp_rev_ff, rsp_idx_ff});

   scan_pos_bound: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff <= POS_W'(SLOTS))
      else $error("scan position past table end");

   busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("ready held after an accepted beat");

   fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed result carries nonzero fields");

   add_marks_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK && kind_ff == KIND_ADD |-> used_ff[addr_ff])
      else $error("added slot not marked used");

endmodule

>>> tb/generational_handle_table_top_test.sv
// self-checking stream testbench for the generational handle table
module generational_handle_table_top_test;
   import ght_pkg::*;

   localparam int ITEM_TARGET = 1900;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 320;
   localparam int DRAIN_WAIT  = 64;

   typedef struct packed {
      logic              ok;
      logic [HIDX_W-1:0] index;
      logic [REV_W-1:0]  revision;
      logic [VAL_W-1:0]  value;
   } table_reply_type;

   class handle_table_checker_type;
      logic              used [SLOTS];
      logic [REV_W-1:0]  revision [SLOTS];
      logic [VAL_W-1:0]  stored [SLOTS];
      logic [POS_W-1:0]  scan_pos;
      table_reply_type   replies_due[$];
      int                errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            used[i]     = 1'b0;
            revision[i] = '0;
            stored[i]   = '0;
         end
         scan_pos = '0;
         errors   = 0;
      endfunction

      function void predict_op(logic [KIND_W-1:0] kind, logic [HIDX_W-1:0] idx,
                               logic [REV_W-1:0] rev, logic [VAL_W-1:0] val);
         table_reply_type reply;
         logic [VAL_W-1:0] keep_mask;
         int slot;
         bit found;
         reply = '0;
         keep_mask = VAL_W'((65'd1 << DATA_WIDTH) - 65'd1);
         found = 1'b0;
         case (kind)
            KIND_ADD: begin
               for (slot = 0; slot < SLOTS; slot++) begin
                  if (!found && !used[slot]) begin
                     found          = 1'b1;
                     used[slot]     = 1'b1;
                     stored[slot]   = val & keep_mask;
                     reply.ok       = 1'b1;
                     reply.index    = HIDX_W'(slot);
                     reply.revision = revision[slot];
                  end
               end
            end
            KIND_GET: begin
               if (int'(idx) < SLOTS && revision[idx] == rev) begin
                  reply.ok    = 1'b1;
                  reply.value = stored[idx];
               end
            end
            KIND_REMOVE: begin
               if (int'(idx) < SLOTS && revision[idx] == rev) begin
                  revision[idx] = revision[idx] + REV_W'(1);
                  used[idx]     = 1'b0;
                  reply.ok      = 1'b1;
               end
            end
            KIND_ITER_START: begin
               scan_pos = '0;
               reply.ok = 1'b1;
            end
            KIND_ITER_NEXT: begin
               while (!found && int'(scan_pos) < SLOTS) begin
                  slot     = int'(scan_pos);
                  scan_pos = scan_pos + POS_W'(1);
                  if (used[slot]) begin
                     found       = 1'b1;
                     reply.ok    = 1'b1;
                     reply.index = HIDX_W'(slot);
                     reply.value = stored[slot];
                  end
               end
            end
            default: ;
         endcase
         replies_due.push_back(reply);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 100)
            $display("mismatch: %s", what);
      endtask

      task compare_reply(logic ok, logic [RSP_DATA_W-1:0] data);
         table_reply_type due;
         logic [HIDX_W-1:0] got_index;
         logic [REV_W-1:0]  got_rev;
         logic [VAL_W-1:0]  got_value;
         got_index = data[HIDX_W-1:0];
         got_rev   = data[HIDX_W +: REV_W];
         got_value = data[HIDX_W+REV_W +: VAL_W];
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat ok=%b data=%h", ok, data));
         end else begin
            due = replies_due.pop_front();
            if (ok !== due.ok)
               report_mismatch($sformatf("ok %b, want %b", ok, due.ok));
            if (got_index !== due.index)
               report_mismatch($sformatf("index %0d, want %0d", got_index, due.index));
            if (got_rev !== due.revision)
               report_mismatch($sformatf("revision %h, want %h", got_rev, due.revision));
            if (got_value !== due.value)
               report_mismatch($sformatf("value %h, want %h", got_value, due.value));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // slot_index, handle_revision, entry_value
   logic [KIND_W-1:0]     req_tuser = '0;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // out_index, out_revision, out_value
   logic                  rsp_tuser;       // ok

   handle_table_checker_type table_check;
   int cycle_count = 0;
   int issued = 0;
   int burst_left = 0;
   int long_holds_asked = 0;
   int long_holds_done = 0;
   int hold_left = 0;
   int rx_cycles = 0;

   generational_handle_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("generational_handle_table_top_test: done, errors");
         $finish;
      end
   end

   // receiver: checks beats and stalls on its own schedule
   always @(posedge clock) begin
      if (!reset) begin
         rx_cycles++;
         if (rsp_tvalid && rsp_tready)
            table_check.compare_reply(rsp_tuser, rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_holds_done != long_holds_asked) begin
            long_holds_done++;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycles / 280) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_cycles % 5 != 0);
            endcase
         end
      end
   end

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 10);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic issue(logic [KIND_W-1:0] kind, logic [HIDX_W-1:0] idx,
                        logic [REV_W-1:0] rev, logic [VAL_W-1:0] val);
      pace();
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({val, rev, idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_check.predict_op(kind, idx, rev, val);
      issued++;
   endtask

   // handles with a slot's current revision, in use when prefer_used finds one, now and then a stale one
   task automatic issue_handle(logic [KIND_W-1:0] kind, bit prefer_used);
      logic [HIDX_W-1:0] idx;
      logic [REV_W-1:0]  rev;
      bit found;
      found = 1'b0;
      idx = HIDX_W'($urandom_range(0, SLOTS - 1));
      for (int t = 0; t < 8; t++) begin
         if (prefer_used && !found && !table_check.used[idx])
            idx = HIDX_W'($urandom_range(0, SLOTS - 1));
         found = table_check.used[idx];
      end
      rev = table_check.revision[idx];
      if ($urandom_range(0, 9) == 0)
         rev = rev + REV_W'($urandom_range(1, 3));
      issue(kind, idx, rev, $urandom);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (table_check.replies_due.size() != 0) @(posedge clock);
   endtask

   // any kind code, the unused ones included
   function automatic logic [KIND_W-1:0] KIND_TYPE_ANY();
      return KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
   endfunction

   initial begin
      int phase;
      int len;
      int choice;
      bit drained_once;
      logic [REV_W-1:0] rev;
      table_check = new();
      drained_once = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed
      issue(KIND_ITER_NEXT, '0, '0, '0);
      issue(KIND_ITER_NEXT, '0, '0, '0);
      issue(KIND_GET, 5'd0, 32'h0, 32'h0);
      issue(KIND_GET, 5'd31, 32'h1, 32'h0);
      issue(KIND_ADD, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(KIND_ADD, '0, '0, 32'h0000_0000);
      issue(KIND_ADD, '0, '0, 32'hA5A5_A5A5);
      issue(KIND_GET, 5'd0, 32'h0, 32'h0);
      issue(KIND_REMOVE, 5'd1, 32'h0, 32'h0);
      issue(KIND_REMOVE, 5'd1, 32'h0, 32'h0);
      issue(KIND_GET, 5'd1, 32'h1, 32'h0);
      issue(KIND_REMOVE, 5'd31, 32'h0, 32'h0);
      issue(KIND_GET, 5'd31, 32'hFFFF_FFFF, 32'h0);
      issue(KIND_ADD, '0, '0, 32'h5A5A_5A5A);
      issue(KIND_ITER_START, '0, '0, '0);
      repeat (4) issue(KIND_ITER_NEXT, '0, '0, '0);
      issue(KIND_ITER_NEXT, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(3'd5, 5'd2, 32'h0, 32'h1234_5678);
      issue(3'd6, 5'd0, 32'h0, 32'h0);
      issue(3'd7, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(KIND_REMOVE, 5'd2, 32'hFFFF_FFFF, 32'h0);

      // random phases
      while (issued < ITEM_TARGET) begin
         if (issued > 400 && long_holds_asked == 0)
            long_holds_asked <= 1;
         if (issued > 1400 && long_holds_asked == 1)
            long_holds_asked <= 2;
         if (issued > 900 && !drained_once) begin
            drained_once = 1'b1;
            wait_drained();
         end
         phase = $urandom_range(0, 5);
         len = $urandom_range(10, 60);
         case (phase)
            0: repeat (len) begin
               choice = $urandom_range(0, 9);
               if (choice < 6) issue(KIND_ADD, HIDX_W'($urandom), $urandom, $urandom);
               else if (choice < 8) issue_handle(KIND_GET, 1'b1);
               else if (choice < 9) issue_handle(KIND_REMOVE, 1'b1);
               else issue(KIND_ITER_NEXT, HIDX_W'($urandom), $urandom, $urandom);
            end
            1: repeat (len) begin
               choice = $urandom_range(0, 9);
               if (choice < 6) issue_handle(KIND_REMOVE, 1'b1);
               else if (choice < 8) issue_handle(KIND_GET, 1'b0);
               else if (choice < 9) issue(KIND_ADD, HIDX_W'($urandom), $urandom, $urandom);
               else issue(KIND_ITER_NEXT, HIDX_W'($urandom), $urandom, $urandom);
            end
            2: repeat (36) issue(KIND_ADD, HIDX_W'($urandom), $urandom, $urandom);
            3: begin
               issue(KIND_ITER_START, HIDX_W'($urandom), $urandom, $urandom);
               repeat ($urandom_range(5, 36))
                  issue(KIND_ITER_NEXT, HIDX_W'($urandom), $urandom, $urandom);
            end
            4: repeat (len) begin
               choice = $urandom_range(0, 3);
               rev = $urandom;
               if (choice == 0)
                  issue_handle(KIND_GET, 1'b0);
               else
                  issue(KIND_TYPE_ANY(), HIDX_W'($urandom), rev, $urandom);
            end
            default: repeat (len) begin
               choice = $urandom_range(0, 4);
               if (choice == int'(KIND_GET) || choice == int'(KIND_REMOVE))
                  issue_handle(KIND_W'(choice), $urandom_range(0, 9) < 7);
               else
                  issue(KIND_W'(choice), HIDX_W'($urandom), $urandom, $urandom);
            end
         endcase
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (table_check.errors == 0 && table_check.replies_due.size() == 0)
         $display("generational_handle_table_top_test: done, clean");
      else
         $display("generational_handle_table_top_test: done, errors");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ght_pkg.sv
hw/rtl/generational_handle_table_top.sv
tb/generational_handle_table_top_test.sv
